@@ hw/rtl/psu_pkg.sv @@
// ----------------------------------------------------------------------------
// PNG scanline unfilter package
// Shared constants, register indexes, filter codes, the stage token type and
// the Paeth predictor.
// ----------------------------------------------------------------------------
package psu_pkg;

   // Default sizes
   localparam int DEF_MAX_ROW_BYTES = 8192;
   localparam int DEF_MAX_BPP       = 4;

   // Field and register widths
   localparam int BYTE_W      = 8;
   localparam int BPP_W       = 3;
   localparam int ROW_BYTES_W = 14;
   localparam int CSR_DATA_W  = 14;
   localparam int CSR_INDEX_W = 1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTES_PER_PIXEL = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_BYTES       = 1'd1;

   // Filter type codes
   localparam logic [2:0] FILT_NONE  = 3'd0;
   localparam logic [2:0] FILT_SUB   = 3'd1;
   localparam logic [2:0] FILT_UP    = 3'd2;
   localparam logic [2:0] FILT_AVG   = 3'd3;
   localparam logic [2:0] FILT_PAETH = 3'd4;

   // Work handed from the control stage to the reconstruction stage
   typedef enum logic [1:0] {
      TOK_DATA  = 2'd0,
      TOK_CLEAR = 2'd1,
      TOK_ERROR = 2'd2
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type       kind;
      logic [2:0]         filt;
      logic               first_row;
      logic               row_end;
      logic [BYTE_W-1:0]  x;
   } token_type;

   // Paeth predictor, ties go to a, then b
   function automatic logic [BYTE_W-1:0] paeth_pick(input logic [BYTE_W-1:0] a,
                                                     input logic [BYTE_W-1:0] b,
                                                     input logic [BYTE_W-1:0] c);
      logic signed [10:0] sa;
      logic signed [10:0] sb;
      logic signed [10:0] sc;
      logic signed [10:0] da;
      logic signed [10:0] db;
      logic signed [10:0] dc;
      logic [10:0]        pa;
      logic [10:0]        pb;
      logic [10:0]        pc;
      logic [BYTE_W-1:0]  pick;
      sa = signed'({3'b000, a});
      sb = signed'({3'b000, b});
      sc = signed'({3'b000, c});
      da = sb - sc;
      db = sa - sc;
      dc = sa + sb - sc - sc;
      pa = (da < 0) ? 11'(-da) : 11'(da);
      pb = (db < 0) ? 11'(-db) : 11'(db);
      pc = (dc < 0) ? 11'(-dc) : 11'(dc);
      if (pa <= pb && pa <= pc) begin
         pick = a;
      end else if (pb <= pc) begin
         pick = b;
      end else begin
         pick = c;
      end
      return pick;
   endfunction

endpackage

@@ hw/rtl/psu_stream_ifs.sv @@
// ----------------------------------------------------------------------------
// PNG scanline unfilter channels
// Request channel (filtered stream bytes) and response channel (pixel bytes).
// ----------------------------------------------------------------------------
interface psu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] raw_byte;
   logic       image_start;

   modport source (output valid, output raw_byte, output image_start, input ready);
   modport sink   (input valid, input raw_byte, input image_start, output ready);
endinterface

interface psu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_byte;
   logic       row_end;
   logic       status;

   modport source (output valid, output pixel_byte, output row_end, output status,
                   input ready);
   modport sink   (input valid, input pixel_byte, input row_end, input status,
                   output ready);
endinterface

@@ hw/rtl/psu_row_mem.sv @@
// ----------------------------------------------------------------------------
// PNG scanline unfilter row memory
// One-read one-write RAM holding the row above, registered read data.
// ----------------------------------------------------------------------------
module psu_row_mem #(
   parameter int DEPTH  = psu_pkg::DEF_MAX_ROW_BYTES,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [psu_pkg::BYTE_W-1:0] rd_data,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [psu_pkg::BYTE_W-1:0] wr_data
);

   logic [psu_pkg::BYTE_W-1:0] mem [DEPTH];
   logic [psu_pkg::BYTE_W-1:0] rd_data_ff;

   // Write the rebuilt byte
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read the byte above
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/psu_ctrl.sv @@
// ----------------------------------------------------------------------------
// PNG scanline unfilter control stage
// Holds the configuration registers, tracks column, filter type, first row and
// error hold, issues the row memory read per request and a token unless held.
// ----------------------------------------------------------------------------
module psu_ctrl #(
   parameter int  MAX_ROW_BYTES = psu_pkg::DEF_MAX_ROW_BYTES,
   parameter int  MAX_BPP       = psu_pkg::DEF_MAX_BPP,
   localparam int COL_W         = $clog2(MAX_ROW_BYTES + 1),
   localparam int ADDR_W        = $clog2(MAX_ROW_BYTES),
   localparam int BPP_IW        = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [psu_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [psu_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             accept,
   input  logic [psu_pkg::BYTE_W-1:0]       raw_byte,
   input  logic                             image_start,
   output logic                             tok_valid,
   output psu_pkg::token_type               tok,
   output logic [ADDR_W-1:0]                rd_addr,
   output logic [BPP_IW-1:0]                bpp_sel
);

   localparam int RB_CW = (COL_W > psu_pkg::ROW_BYTES_W) ? COL_W : psu_pkg::ROW_BYTES_W;

   logic [psu_pkg::BPP_W-1:0]       bpp_ff;
   logic [psu_pkg::BPP_W-1:0]       bpp_in;
   logic [psu_pkg::ROW_BYTES_W-1:0] row_bytes_ff;
   logic [psu_pkg::ROW_BYTES_W-1:0] row_bytes_in;
   logic [COL_W-1:0]                column_ff;
   logic [COL_W-1:0]                column_in;
   logic [2:0]                      filt_ff;
   logic [2:0]                      filt_in;
   logic                            first_row_ff;
   logic                            first_row_in;
   logic                            hold_ff;
   logic                            hold_in;

   logic [3:0]       bpp_wide;
   logic [RB_CW-1:0] rb_wide;
   logic [COL_W-1:0] rb_eff;
   logic [COL_W-1:0] col;
   logic             first;
   logic             hold;

   // Clamp the registers into their working ranges
   always_comb begin
      bpp_wide = {1'b0, bpp_ff};
      if (bpp_wide == 4'd0) begin
         bpp_wide = 4'd1;
      end else if (bpp_wide > 4'(MAX_BPP)) begin
         bpp_wide = 4'(MAX_BPP);
      end
      rb_wide = RB_CW'(row_bytes_ff);
      if (rb_wide == '0) begin
         rb_wide = RB_CW'(1);
      end else if (rb_wide > RB_CW'(MAX_ROW_BYTES)) begin
         rb_wide = RB_CW'(MAX_ROW_BYTES);
      end
      rb_eff = COL_W'(rb_wide);
   end

   assign bpp_sel = BPP_IW'(bpp_wide - 4'd1);

   // Take configuration writes
   always_comb begin
      bpp_in       = bpp_ff;
      row_bytes_in = row_bytes_ff;
      if (csr_wr_en) begin
         case (csr_index)
            psu_pkg::CSR_BYTES_PER_PIXEL: begin
               bpp_in = csr_wdata[psu_pkg::BPP_W-1:0];
            end
            psu_pkg::CSR_ROW_BYTES: begin
               row_bytes_in = csr_wdata[psu_pkg::ROW_BYTES_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Sort the request into drop, filter byte, bad filter or data byte
   always_comb begin
      col          = image_start ? '0 : column_ff;
      first        = image_start ? 1'b1 : first_row_ff;
      hold         = image_start ? 1'b0 : hold_ff;
      column_in    = column_ff;
      filt_in      = filt_ff;
      first_row_in = first_row_ff;
      hold_in      = hold_ff;
      tok_valid    = 1'b0;
      tok.kind      = psu_pkg::TOK_DATA;
      tok.filt      = filt_ff;
      tok.first_row = first;
      tok.row_end   = 1'b0;
      tok.x         = raw_byte;
      rd_addr       = ADDR_W'(col - COL_W'(1));
      if (accept) begin
         column_in    = col;
         first_row_in = first;
         hold_in      = hold;
         if (!hold) begin
            tok_valid = 1'b1;
            if (col == '0) begin
               if (raw_byte > 8'(psu_pkg::FILT_PAETH)) begin
                  tok.kind = psu_pkg::TOK_ERROR;
                  hold_in  = 1'b1;
               end else begin
                  tok.kind  = psu_pkg::TOK_CLEAR;
                  filt_in   = raw_byte[2:0];
                  column_in = COL_W'(1);
               end
            end else if (col >= rb_eff) begin
               tok.row_end  = 1'b1;
               column_in    = '0;
               first_row_in = 1'b0;
            end else begin
               column_in = col + COL_W'(1);
            end
         end
      end
   end

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff       <= psu_pkg::BPP_W'(1);
         row_bytes_ff <= psu_pkg::ROW_BYTES_W'(1);
         column_ff    <= '0;
         filt_ff      <= psu_pkg::FILT_NONE;
         first_row_ff <= 1'b1;
         hold_ff      <= 1'b0;
      end else begin
         bpp_ff       <= bpp_in;
         row_bytes_ff <= row_bytes_in;
         column_ff    <= column_in;
         filt_ff      <= filt_in;
         first_row_ff <= first_row_in;
         hold_ff      <= hold_in;
      end
   end

endmodule

@@ hw/rtl/psu_recon.sv @@
// ----------------------------------------------------------------------------
// PNG scanline unfilter reconstruction stage
// Rebuilds each byte from the left, above and above-left bytes, writes it back
// to the row memory and loads the response register.
// ----------------------------------------------------------------------------
module psu_recon #(
   parameter int  MAX_ROW_BYTES = psu_pkg::DEF_MAX_ROW_BYTES,
   parameter int  MAX_BPP       = psu_pkg::DEF_MAX_BPP,
   localparam int ADDR_W        = $clog2(MAX_ROW_BYTES),
   localparam int BPP_IW        = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic                        tok_valid,
   input  psu_pkg::token_type          tok,
   input  logic [ADDR_W-1:0]           tok_addr,
   input  logic [BPP_IW-1:0]           bpp_sel,
   input  logic [psu_pkg::BYTE_W-1:0]  above_data,
   output logic                        take_ready,
   output logic                        wr_en,
   output logic [ADDR_W-1:0]           wr_addr,
   output logic [psu_pkg::BYTE_W-1:0]  wr_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [psu_pkg::BYTE_W-1:0]  rsp_pixel_byte,
   output logic                        rsp_row_end,
   output logic                        rsp_status
);

   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   psu_pkg::token_type         s1_tok_ff;
   logic [ADDR_W-1:0]          s1_addr_ff;
   logic [psu_pkg::BYTE_W-1:0] left_ff   [MAX_BPP];
   logic [psu_pkg::BYTE_W-1:0] left_in   [MAX_BPP];
   logic [psu_pkg::BYTE_W-1:0] upleft_ff [MAX_BPP];
   logic [psu_pkg::BYTE_W-1:0] upleft_in [MAX_BPP];
   logic                       out_valid_ff;
   logic                       out_valid_in;
   logic [psu_pkg::BYTE_W-1:0] out_byte_ff;
   logic                       out_row_end_ff;
   logic                       out_status_ff;

   logic                       out_free;
   logic                       fire;
   logic [psu_pkg::BYTE_W-1:0] a;
   logic [psu_pkg::BYTE_W-1:0] b;
   logic [psu_pkg::BYTE_W-1:0] c;
   logic [psu_pkg::BYTE_W:0]   avg_sum;
   logic [psu_pkg::BYTE_W-1:0] pred;
   logic [psu_pkg::BYTE_W-1:0] r;

   // Handshake: a filter byte leaves without a response
   assign out_free   = !out_valid_ff || rsp_ready;
   assign fire       = s1_valid_ff && ((s1_tok_ff.kind == psu_pkg::TOK_CLEAR) || out_free);
   assign take_ready = !s1_valid_ff || fire;

   // Predict and rebuild the byte
   always_comb begin
      a       = left_ff[bpp_sel];
      c       = upleft_ff[bpp_sel];
      b       = s1_tok_ff.first_row ? '0 : above_data;
      avg_sum = {1'b0, a} + {1'b0, b};
      case (s1_tok_ff.filt)
         psu_pkg::FILT_SUB:   pred = a;
         psu_pkg::FILT_UP:    pred = b;
         psu_pkg::FILT_AVG:   pred = avg_sum[psu_pkg::BYTE_W:1];
         psu_pkg::FILT_PAETH: pred = psu_pkg::paeth_pick(a, b, c);
         default:             pred = '0;
      endcase
      r = s1_tok_ff.x + pred;
   end

   // Write back the rebuilt byte as the row above
   assign wr_en   = fire && (s1_tok_ff.kind == psu_pkg::TOK_DATA);
   assign wr_addr = s1_addr_ff;
   assign wr_data = r;

   // Shift the left and above-left history, clear it at a filter byte
   always_comb begin
      for (int k = 0; k < MAX_BPP; k++) begin
         left_in[k]   = left_ff[k];
         upleft_in[k] = upleft_ff[k];
      end
      if (fire) begin
         if (s1_tok_ff.kind == psu_pkg::TOK_DATA) begin
            left_in[0]   = r;
            upleft_in[0] = b;
            for (int k = 1; k < MAX_BPP; k++) begin
               left_in[k]   = left_ff[k-1];
               upleft_in[k] = upleft_ff[k-1];
            end
         end else begin
            for (int k = 0; k < MAX_BPP; k++) begin
               left_in[k]   = '0;
               upleft_in[k] = '0;
            end
         end
      end
   end

   // Stage and response valid
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (fire) begin
         s1_valid_in = 1'b0;
      end
      if (accept && tok_valid) begin
         s1_valid_in = 1'b1;
      end
      out_valid_in = out_valid_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (fire && (s1_tok_ff.kind != psu_pkg::TOK_CLEAR)) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < MAX_BPP; k++) begin
            left_ff[k]   <= '0;
            upleft_ff[k] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         for (int k = 0; k < MAX_BPP; k++) begin
            left_ff[k]   <= left_in[k];
            upleft_ff[k] <= upleft_in[k];
         end
      end
   end

   // Load the stage payload
   always_ff @(posedge clock) begin
      if (accept && tok_valid) begin
         s1_tok_ff  <= tok;
         s1_addr_ff <= tok_addr;
      end
   end

   // Load the response payload
   always_ff @(posedge clock) begin
      if (fire) begin
         case (s1_tok_ff.kind)
            psu_pkg::TOK_DATA: begin
               out_byte_ff    <= r;
               out_row_end_ff <= s1_tok_ff.row_end;
               out_status_ff  <= 1'b0;
            end
            psu_pkg::TOK_ERROR: begin
               out_byte_ff    <= '0;
               out_row_end_ff <= 1'b0;
               out_status_ff  <= 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_pixel_byte = out_byte_ff;
   assign rsp_row_end    = out_row_end_ff;
   assign rsp_status     = out_status_ff;

endmodule

@@ hw/rtl/png_scanline_unfilter.sv @@
// A data byte's pixel reaches rsp through the reconstruction stage register, then the
// response register. Throughput: one request per cycle unless a response stalls,
// set by the row memory's one read and one write port per cycle; a filter byte takes
// a request slot and gives no response.
// Reset: synchronous, clears column, filter, first-row and error-hold state, the
// pixel history and both valids; the row memory is not cleared and needs no pass.
// ----------------------------------------------------------------------------
// PNG scanline unfilter
// Rebuilds PNG filtered rows (None, Sub, Up, Average, Paeth) one byte per
// request, keeping the row above in a single-port-pair RAM.
// ----------------------------------------------------------------------------
module png_scanline_unfilter #(
   parameter int MAX_ROW_BYTES = psu_pkg::DEF_MAX_ROW_BYTES,
   parameter int MAX_BPP       = psu_pkg::DEF_MAX_BPP
) (
   input  logic                            clock,
   input  logic                            reset,
   psu_req_if.sink                         req_chan,
   psu_rsp_if.source                       rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [psu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [psu_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int ADDR_W = $clog2(MAX_ROW_BYTES);
   localparam int BPP_IW = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;

   logic                       accept;
   logic                       take_ready;
   logic                       tok_valid;
   psu_pkg::token_type         tok;
   logic [ADDR_W-1:0]          rd_addr;
   logic [BPP_IW-1:0]          bpp_sel;
   logic [psu_pkg::BYTE_W-1:0] above_data;
   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr;
   logic [psu_pkg::BYTE_W-1:0] wr_data;

   // Take a request when the reconstruction stage can move
   assign req_chan.ready = take_ready;
   assign accept         = req_chan.valid && take_ready;

   psu_ctrl #(
      .MAX_ROW_BYTES (MAX_ROW_BYTES),
      .MAX_BPP       (MAX_BPP)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .accept      (accept),
      .raw_byte    (req_chan.raw_byte),
      .image_start (req_chan.image_start),
      .tok_valid   (tok_valid),
      .tok         (tok),
      .rd_addr     (rd_addr),
      .bpp_sel     (bpp_sel)
   );

   psu_row_mem #(
      .DEPTH  (MAX_ROW_BYTES),
      .ADDR_W (ADDR_W)
   ) u_row_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (above_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   psu_recon #(
      .MAX_ROW_BYTES (MAX_ROW_BYTES),
      .MAX_BPP       (MAX_BPP)
   ) u_recon (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .tok_valid      (tok_valid),
      .tok            (tok),
      .tok_addr       (rd_addr),
      .bpp_sel        (bpp_sel),
      .above_data     (above_data),
      .take_ready     (take_ready),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_pixel_byte (rsp_chan.pixel_byte),
      .rsp_row_end    (rsp_chan.row_end),
      .rsp_status     (rsp_chan.status)
   );

endmodule

@@ hw/rtl/psu_checker.sv @@
// ----------------------------------------------------------------------------
// PNG scanline unfilter port checker
// Port-level properties of the unfilter, bound to the top level.
// ----------------------------------------------------------------------------
module psu_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_pixel_byte,
   input logic       rsp_row_end,
   input logic       rsp_status
);

   // Reset empties the response register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Request side stalls only behind a stalled response
   assert property (@(posedge clock) disable iff (reset)
                    !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled without response backpressure");

   // An error response carries no pixel and no row end
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && rsp_status) |-> (rsp_pixel_byte == 8'd0 && !rsp_row_end))
      else $error("error response with pixel data");

   // Hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && !rsp_ready) |=>
                    (rsp_valid && $stable(rsp_pixel_byte) && $stable(rsp_row_end)
                     && $stable(rsp_status)))
      else $error("stalled response changed");

endmodule

bind png_scanline_unfilter psu_checker u_psu_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_pixel_byte (rsp_chan.pixel_byte),
   .rsp_row_end    (rsp_chan.row_end),
   .rsp_status     (rsp_chan.status)
);
